// ===== sv/cvse_pkg.sv =====
// ============================================================================
// cvse_pkg - shared definitions for the complex value stack engine
// Sizes, operation codes, controller states and the command and status
// structs that join the controller and the datapath.
// ============================================================================
`default_nettype none

package cvse_pkg;

    // storage geometry
    localparam int DEPTH      = 64;
    localparam int PART_WIDTH = 16;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int ENTRY_W    = 2 * PART_WIDTH;
    localparam int FUNC_W     = 3;

    // accumulator holds the sum of up to DEPTH parts
    localparam int SUM_W      = PART_WIDTH + ADDR_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // stream payload width: real, imag, position/count packed, padded to bytes
    localparam int TDATA_W    = ((2 * PART_WIDTH + CNT_W + 7) / 8) * 8;

    // operation codes carried in s_tuser
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_REMOVE = 3'd2,
        FUNC_DROP   = 3'd3,
        FUNC_AVG    = 3'd4
    } func_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    // datapath micro-operations, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH,
        OP_FAULT,
        OP_NOFAULT,
        OP_POP_RD,
        OP_POP_OUT,
        OP_COPY_INIT,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_COPY_END,
        OP_SUM_INIT,
        OP_SUM_STEP,
        OP_DIV_START,
        OP_DIV_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cvse_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              push_ok;
        logic              nonempty;
        logic              remove_ok;
        logic              drop_ok;
        logic              copy_more;
        logic              sum_busy;
        logic              div_busy;
    } cvse_status_t;

endpackage

`default_nettype wire

// ===== sv/cvse_div.sv =====
// ============================================================================
// cvse_div - serial signed divider
// Restoring division of a signed sum by an unsigned count, one quotient bit
// per cycle, truncating toward zero.
// ============================================================================
`default_nettype none

module cvse_div import cvse_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic signed [SUM_W-1:0]      numer,
    input  wire logic        [CNT_W-1:0]      denom,
    output logic                              busy,
    output logic signed      [PART_WIDTH-1:0] quot
);

    logic                 busy_reg, busy_next;
    logic                 neg_reg, neg_next;
    logic [SUM_W-1:0]     dvd_reg, dvd_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] step_reg, step_next;

    logic [CNT_W:0]       rem_shift;
    logic [CNT_W:0]       rem_sub;
    logic                 fits;
    logic [SUM_W-1:0]     quot_mag;

    // one restoring step
    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        step_next = step_reg;
        if (start) begin
            busy_next = 1'b1;
            neg_next  = numer[SUM_W-1];
            dvd_next  = numer[SUM_W-1] ? (~numer + 1'b1) : numer;
            rem_next  = '0;
            den_next  = denom;
            step_next = '0;
        end else if (busy_reg) begin
            dvd_next  = {dvd_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        step_reg <= step_next;
    end

    // restore the sign of the quotient
    assign quot_mag = neg_reg ? (~dvd_reg + 1'b1) : dvd_reg;
    assign quot     = quot_mag[PART_WIDTH-1:0];
    assign busy     = busy_reg;

endmodule

`default_nettype wire

// ===== sv/cvse_datapath.sv =====
// ============================================================================
// cvse_datapath - entry memory, count, accumulators and result registers
// Carries out one micro-operation per cycle as commanded by the controller
// and reports the conditions the controller branches on.
// ============================================================================
`default_nettype none

module cvse_datapath import cvse_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cvse_cmd_t                    cmd,
    output cvse_status_t                      status,
    input  wire logic        [FUNC_W-1:0]     func_in,
    input  wire logic signed [PART_WIDTH-1:0] real_in,
    input  wire logic signed [PART_WIDTH-1:0] imag_in,
    input  wire logic        [CNT_W-1:0]      position_in,
    input  wire logic                         cfg_wr_en,
    input  wire logic        [CNT_W-1:0]      cfg_wr_data,
    output logic signed      [PART_WIDTH-1:0] real_out,
    output logic signed      [PART_WIDTH-1:0] imag_out,
    output logic                              fault_out,
    output logic             [CNT_W-1:0]      fill_count_out
);

    // entry memory
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;

    logic [CNT_W-1:0]      cap_reg, cap_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [PART_WIDTH-1:0] re_in_reg, re_in_next;
    logic [PART_WIDTH-1:0] im_in_reg, im_in_next;
    logic [CNT_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      src_reg, src_next;
    logic [ADDR_W-1:0]     dst_reg, dst_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  vld_reg, vld_next;
    logic [SUM_W-1:0]      acc_re_reg, acc_re_next;
    logic [SUM_W-1:0]      acc_im_reg, acc_im_next;
    logic [PART_WIDTH-1:0] res_re_reg, res_re_next;
    logic [PART_WIDTH-1:0] res_im_reg, res_im_next;
    logic                  res_fault_reg, res_fault_next;
    logic [PART_WIDTH-1:0] out_re_reg;
    logic [PART_WIDTH-1:0] out_im_reg;
    logic                  out_fault_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      count_m1;
    logic [PART_WIDTH-1:0] rd_re;
    logic [PART_WIDTH-1:0] rd_im;
    logic                  div_start;
    logic                  div_busy_re, div_busy_im;
    logic [PART_WIDTH-1:0] quot_re, quot_im;

    // push limit saturates at the memory depth
    assign limit    = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign count_m1 = count_reg - 1'b1;
    assign rd_re    = rd_data_reg[PART_WIDTH-1:0];
    assign rd_im    = rd_data_reg[ENTRY_W-1:PART_WIDTH];

    // memory port control
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = dst_reg;
        mem_wr_data = rd_data_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = src_reg[ADDR_W-1:0];
        unique case (cmd.op)
            OP_PUSH: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_reg[ADDR_W-1:0];
                mem_wr_data = {im_in_reg, re_in_reg};
            end
            OP_POP_RD: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = count_m1[ADDR_W-1:0];
            end
            OP_COPY_RD: begin
                mem_rd_en   = 1'b1;
            end
            OP_COPY_WR: begin
                mem_wr_en   = 1'b1;
            end
            OP_SUM_STEP: begin
                mem_rd_en   = idx_reg < count_reg;
                mem_rd_addr = idx_reg[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    // register next values per micro-operation
    always_comb begin
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        re_in_next     = re_in_reg;
        im_in_next     = im_in_reg;
        pos_next       = pos_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        idx_next       = idx_reg;
        vld_next       = vld_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        res_re_next    = res_re_reg;
        res_im_next    = res_im_reg;
        res_fault_next = res_fault_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                func_next  = func_in;
                re_in_next = real_in;
                im_in_next = imag_in;
                pos_next   = position_in;
            end
            OP_PUSH: begin
                count_next     = count_reg + 1'b1;
                res_re_next    = '0;
                res_im_next    = '0;
                res_fault_next = 1'b0;
            end
            OP_FAULT: begin
                res_re_next    = '0;
                res_im_next    = '0;
                res_fault_next = 1'b1;
            end
            OP_NOFAULT: begin
                res_re_next    = '0;
                res_im_next    = '0;
                res_fault_next = 1'b0;
            end
            OP_POP_RD: begin
                count_next = count_m1;
            end
            OP_POP_OUT: begin
                res_re_next    = rd_re;
                res_im_next    = rd_im;
                res_fault_next = 1'b0;
            end
            OP_COPY_INIT: begin
                // remove closes a gap of one, drop moves down by k
                if (func_reg == FUNC_REMOVE) begin
                    dst_next = pos_reg[ADDR_W-1:0];
                    src_next = pos_reg + 1'b1;
                end else begin
                    dst_next = '0;
                    src_next = pos_reg;
                end
                res_re_next    = '0;
                res_im_next    = '0;
                res_fault_next = 1'b0;
            end
            OP_COPY_WR: begin
                src_next = src_reg + 1'b1;
                dst_next = dst_reg + 1'b1;
            end
            OP_COPY_END: begin
                count_next = (func_reg == FUNC_REMOVE) ? count_m1 : (count_reg - pos_reg);
            end
            OP_SUM_INIT: begin
                idx_next    = '0;
                vld_next    = 1'b0;
                acc_re_next = '0;
                acc_im_next = '0;
            end
            OP_SUM_STEP: begin
                // read the next entry while adding the one read last cycle
                if (idx_reg < count_reg) begin
                    idx_next = idx_reg + 1'b1;
                    vld_next = 1'b1;
                end else begin
                    vld_next = 1'b0;
                end
                if (vld_reg) begin
                    acc_re_next = acc_re_reg + {{ADDR_W{rd_re[PART_WIDTH-1]}}, rd_re};
                    acc_im_next = acc_im_reg + {{ADDR_W{rd_im[PART_WIDTH-1]}}, rd_im};
                end
            end
            OP_DIV_OUT: begin
                res_re_next    = quot_re;
                res_im_next    = quot_im;
                res_fault_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CNT_W'(DEPTH);
            count_reg <= '0;
        end else begin
            cap_reg   <= cap_next;
            count_reg <= count_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        re_in_reg     <= re_in_next;
        im_in_reg     <= im_in_next;
        pos_reg       <= pos_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        idx_reg       <= idx_next;
        vld_reg       <= vld_next;
        acc_re_reg    <= acc_re_next;
        acc_im_reg    <= acc_im_next;
        res_re_reg    <= res_re_next;
        res_im_reg    <= res_im_next;
        res_fault_reg <= res_fault_next;
        if (cmd.out_load) begin
            out_re_reg    <= res_re_reg;
            out_im_reg    <= res_im_reg;
            out_fault_reg <= res_fault_reg;
            out_count_reg <= count_reg;
        end
    end

    // averaging dividers, real and imaginary in lockstep
    assign div_start = cmd.op == OP_DIV_START;

    cvse_div u_div_re (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (acc_re_reg),
        .denom   (count_reg),
        .busy    (div_busy_re),
        .quot    (quot_re)
    );

    cvse_div u_div_im (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (acc_im_reg),
        .denom   (count_reg),
        .busy    (div_busy_im),
        .quot    (quot_im)
    );

    // status for the controller
    assign status.func      = func_reg;
    assign status.push_ok   = count_reg < limit;
    assign status.nonempty  = count_reg != '0;
    assign status.remove_ok = pos_reg < count_reg;
    assign status.drop_ok   = pos_reg <= count_reg;
    assign status.copy_more = src_reg < count_reg;
    assign status.sum_busy  = (idx_reg < count_reg) || vld_reg;
    assign status.div_busy  = div_busy_re || div_busy_im;

    assign real_out       = out_re_reg;
    assign imag_out       = out_im_reg;
    assign fault_out      = out_fault_reg;
    assign fill_count_out = out_count_reg;

endmodule

`default_nettype wire

// ===== sv/cvse_ctrl.sv =====
// ============================================================================
// cvse_ctrl - operation sequencer
// Accepts one item at a time, steps the datapath through the operation and
// hands the result to the output register when it is free.
// ============================================================================
`default_nettype none

module cvse_ctrl import cvse_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire cvse_status_t status,
    output cvse_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        m_valid_next = m_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_DONE;
                unique case (status.func)
                    FUNC_PUSH: begin
                        cmd.op = status.push_ok ? OP_PUSH : OP_FAULT;
                    end
                    FUNC_POP: begin
                        if (status.nonempty) begin
                            cmd.op     = OP_POP_RD;
                            state_next = ST_POP_WAIT;
                        end else begin
                            cmd.op = OP_FAULT;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (status.remove_ok) begin
                            cmd.op     = OP_COPY_INIT;
                            state_next = ST_COPY_RD;
                        end else begin
                            cmd.op = OP_FAULT;
                        end
                    end
                    FUNC_DROP: begin
                        if (status.drop_ok) begin
                            cmd.op     = OP_COPY_INIT;
                            state_next = ST_COPY_RD;
                        end else begin
                            cmd.op = OP_FAULT;
                        end
                    end
                    FUNC_AVG: begin
                        if (status.nonempty) begin
                            cmd.op     = OP_SUM_INIT;
                            state_next = ST_SUM;
                        end else begin
                            cmd.op = OP_FAULT;
                        end
                    end
                    default: begin
                        cmd.op = OP_NOFAULT;
                    end
                endcase
            end
            ST_POP_WAIT: begin
                cmd.op     = OP_POP_OUT;
                state_next = ST_DONE;
            end
            ST_COPY_RD: begin
                if (status.copy_more) begin
                    cmd.op     = OP_COPY_RD;
                    state_next = ST_COPY_WR;
                end else begin
                    cmd.op     = OP_COPY_END;
                    state_next = ST_DONE;
                end
            end
            ST_COPY_WR: begin
                cmd.op     = OP_COPY_WR;
                state_next = ST_COPY_RD;
            end
            ST_SUM: begin
                if (status.sum_busy) begin
                    cmd.op = OP_SUM_STEP;
                end else begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!status.div_busy) begin
                    cmd.op     = OP_DIV_OUT;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // move the result out once the output register is free
                if (!m_valid_reg || out_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== sv/complex_value_stack_engine.sv =====
// ============================================================================
// complex_value_stack_engine - bounded stack of complex values
// Push, pop, remove at index, drop leading entries and average over a
// stream interface, one result item per input item.
// ============================================================================
// One item is worked on at a time; its result sits in an output register so
// the next item is taken while that result waits. Push, faulting operations
// and undefined codes go from decode straight to the output stage; pop adds
// a wait for the entry read. Remove and drop copy each moved entry with a
// read state and then a write state of the entry memory; the most entries
// move on a drop of zero on a full store. Average reads the count n of
// entries one per cycle, then runs a bit-serial divider of PART_WIDTH +
// log2(DEPTH) steps. The capacity register may be rewritten while idle; the
// push limit it sets saturates at DEPTH. Faults return zero value parts.
`default_nettype none

module complex_value_stack_engine import cvse_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: capacity_limit
    input  wire logic               cfg_wr_en,
    input  wire logic [CNT_W-1:0]   cfg_wr_data,
    // input items
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // real_in [15:0], imag_in [31:16], position [38:32], zero pad
    input  wire logic [TDATA_W-1:0] s_tdata,
    // func [2:0]
    input  wire logic [FUNC_W-1:0]  s_tuser,
    // result items
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // real_out [15:0], imag_out [31:16], fill_count [38:32], zero pad
    output logic [TDATA_W-1:0]      m_tdata,
    // fault [0]
    output logic [0:0]              m_tuser
);

    cvse_cmd_t             cmd;
    cvse_status_t          status;
    logic [PART_WIDTH-1:0] real_out;
    logic [PART_WIDTH-1:0] imag_out;
    logic                  fault;
    logic [CNT_W-1:0]      fill_count;

    cvse_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    cvse_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .func_in        (s_tuser),
        .real_in        (s_tdata[PART_WIDTH-1:0]),
        .imag_in        (s_tdata[ENTRY_W-1:PART_WIDTH]),
        .position_in    (s_tdata[ENTRY_W+CNT_W-1:ENTRY_W]),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .real_out       (real_out),
        .imag_out       (imag_out),
        .fault_out      (fault),
        .fill_count_out (fill_count)
    );

    // pack the result item
    assign m_tdata = {{(TDATA_W - ENTRY_W - CNT_W){1'b0}}, fill_count, imag_out, real_out};
    assign m_tuser = fault;

    // a faulting result never carries a value
    a_fault_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && fault) |-> (real_out == '0 && imag_out == '0))
        else $error("fault result with nonzero value");

    // reported fill never exceeds the memory depth
    a_fill_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (fill_count <= CNT_W'(DEPTH)))
        else $error("fill count above depth");

    // one item at a time: no accept right after an accept
    a_one_item : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in work");

    // the output register is loaded only when its item is gone or leaving
    a_out_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten before delivery");

endmodule

`default_nettype wire

// ===== tb/sv/complex_value_stack_engine_tb.sv =====
// ============================================================================
// complex_value_stack_engine_tb - self-checking bench for the complex stack
// Drives push, pop, remove, drop and average items over the input stream,
// predicts every result from a local model of the store and checks each
// result item field by field, under random gaps, stalls and a long hold-off.
// ============================================================================
`timescale 1ns / 100ps

module complex_value_stack_engine_tb;
    import cvse_pkg::*;

    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNDEF_HI = 3'd7;
    localparam logic signed [PART_WIDTH-1:0] PART_MAX = 16'sh7fff;
    localparam logic signed [PART_WIDTH-1:0] PART_MIN = 16'sh8000;

    typedef struct {
        logic [PART_WIDTH-1:0] re;
        logic [PART_WIDTH-1:0] im;
        logic                  fault;
        logic [CNT_W-1:0]      count;
    } stack_result_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CNT_W-1:0]   cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]  s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;

    // local copy of the store
    logic signed [PART_WIDTH-1:0] store_re [DEPTH];
    logic signed [PART_WIDTH-1:0] store_im [DEPTH];
    int fill = 0;
    int cap_setting = DEPTH;

    stack_result_t pending_results [$];
    int mismatch_count = 0;
    int cycle_count = 0;

    // idling controls for the sender and the ready process
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int hold_request = 0;

    complex_value_stack_engine uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // one stack operation on the local store, returns the expected item
    function automatic stack_result_t apply_stack_op(input logic [FUNC_W-1:0] code,
                                                     input logic signed [PART_WIDTH-1:0] re_in,
                                                     input logic signed [PART_WIDTH-1:0] im_in,
                                                     input logic [CNT_W-1:0] pos);
        stack_result_t res;
        int limit;
        int k;
        longint sum_re;
        longint sum_im;
        res.re = '0;
        res.im = '0;
        res.fault = 1'b0;
        limit = (cap_setting < DEPTH) ? cap_setting : DEPTH;
        k = int'(pos);
        sum_re = 0;
        sum_im = 0;
        case (code)
            FUNC_PUSH: begin
                if (fill < limit) begin
                    store_re[fill] = re_in;
                    store_im[fill] = im_in;
                    fill++;
                end else begin
                    res.fault = 1'b1;
                end
            end
            FUNC_POP: begin
                if (fill > 0) begin
                    fill--;
                    res.re = store_re[fill];
                    res.im = store_im[fill];
                end else begin
                    res.fault = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (k < fill) begin
                    for (int i = k; i + 1 < fill; i++) begin
                        store_re[i] = store_re[i+1];
                        store_im[i] = store_im[i+1];
                    end
                    fill--;
                end else begin
                    res.fault = 1'b1;
                end
            end
            FUNC_DROP: begin
                if (k <= fill) begin
                    for (int i = 0; i + k < fill; i++) begin
                        store_re[i] = store_re[i+k];
                        store_im[i] = store_im[i+k];
                    end
                    fill -= k;
                end else begin
                    res.fault = 1'b1;
                end
            end
            FUNC_AVG: begin
                if (fill > 0) begin
                    for (int i = 0; i < fill; i++) begin
                        sum_re += store_re[i];
                        sum_im += store_im[i];
                    end
                    // signed division truncates toward zero
                    res.re = PART_WIDTH'(sum_re / fill);
                    res.im = PART_WIDTH'(sum_im / fill);
                end else begin
                    res.fault = 1'b1;
                end
            end
            default: ;
        endcase
        res.count = CNT_W'(fill);
        return res;
    endfunction

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // part value with extra weight on the extremes
    function automatic logic [PART_WIDTH-1:0] rand_part();
        case ($urandom_range(0, 11))
            0: return PART_MAX;
            1: return PART_MIN;
            2: return '0;
            3: return '1;
            default: return PART_WIDTH'($urandom_range(0, 65535));
        endcase
    endfunction

    // offer one item, wait for the handshake, record its expected result
    task automatic send_item(input logic [FUNC_W-1:0] code,
                             input logic [PART_WIDTH-1:0] re,
                             input logic [PART_WIDTH-1:0] im,
                             input logic [CNT_W-1:0] pos);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({pos, im, re});
        s_tuser  <= code;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_stack_op(code, re, im, pos));
        @(negedge aclk);
    endtask

    // stop offering and let every pending result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_capacity(input int value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CNT_W'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_setting = value;
    endtask

    // random operation, mostly well-formed for the current fill level
    task automatic random_op(output logic [FUNC_W-1:0] code,
                             output logic [PART_WIDTH-1:0] re,
                             output logic [PART_WIDTH-1:0] im,
                             output logic [CNT_W-1:0] pos);
        int r;
        int small_max;
        r = $urandom_range(0, 99);
        re = rand_part();
        im = rand_part();
        pos = CNT_W'($urandom_range(0, 127));
        small_max = (fill < 2) ? fill : 2;
        if (r < 45) begin
            code = FUNC_PUSH;
        end else if (r < 62) begin
            code = FUNC_POP;
        end else if (r < 74) begin
            code = FUNC_REMOVE;
            if ($urandom_range(0, 9) != 0 && fill > 0)
                pos = CNT_W'($urandom_range(0, fill - 1));
        end else if (r < 84) begin
            code = FUNC_DROP;
            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 3) == 0)
                    pos = CNT_W'($urandom_range(0, fill));
                else
                    pos = CNT_W'($urandom_range(0, small_max));
            end
        end else if (r < 96) begin
            code = FUNC_AVG;
        end else begin
            code = FUNC_UNDEF_LO + FUNC_W'($urandom_range(0, FUNC_UNDEF_HI - FUNC_UNDEF_LO));
        end
    endtask

    // empty store, bad positions and undefined codes
    task automatic test_empty_store();
        send_item(FUNC_POP, '0, '0, '0);
        send_item(FUNC_AVG, '0, '0, '0);
        send_item(FUNC_REMOVE, '0, '0, '0);
        send_item(FUNC_DROP, '0, '0, '0);
        send_item(FUNC_DROP, '0, '0, 7'd1);
        send_item(FUNC_UNDEF_LO, PART_MAX, PART_MIN, 7'd127);
        send_item(FUNC_UNDEF_HI, '1, '1, 7'd64);
    endtask

    // every operation with extreme parts and boundary positions
    task automatic test_stack_ops();
        send_item(FUNC_PUSH, PART_MAX, PART_MIN, 7'd127);
        send_item(FUNC_PUSH, PART_MIN, PART_MAX, '0);
        send_item(FUNC_PUSH, '1, 16'd1, '0);
        send_item(FUNC_AVG, '0, '0, '0);
        send_item(FUNC_REMOVE, '0, '0, 7'd3);
        send_item(FUNC_REMOVE, '0, '0, 7'd1);
        send_item(FUNC_AVG, '0, '0, '0);
        send_item(FUNC_POP, '0, '0, '0);
        send_item(FUNC_PUSH, '0, '0, '0);
        send_item(FUNC_DROP, '0, '0, 7'd2);
        send_item(FUNC_PUSH, 16'd5, -16'sd7, '0);
        send_item(FUNC_PUSH, -16'sd4, 16'd4, '0);
        send_item(FUNC_PUSH, 16'd1, 16'd1, '0);
        send_item(FUNC_DROP, '0, '0, 7'd4);
        send_item(FUNC_DROP, '0, '0, 7'd1);
        send_item(FUNC_AVG, '0, '0, '0);
        send_item(FUNC_REMOVE, '0, '0, 7'd1);
        send_item(FUNC_POP, '0, '0, '0);
    endtask

    // push against a zero and a small capacity
    task automatic test_capacity_limit();
        set_capacity(0);
        send_item(FUNC_PUSH, 16'd9, 16'd9, '0);
        set_capacity(2);
        send_item(FUNC_PUSH, 16'd3, -16'sd3, '0);
        send_item(FUNC_PUSH, 16'd2, -16'sd2, '0);
        send_item(FUNC_PUSH, 16'd1, -16'sd1, '0);
        set_capacity(DEPTH);
    endtask

    // receiver holds off while items keep coming, input must stall
    task automatic test_backpressure();
        logic [FUNC_W-1:0] code;
        logic [PART_WIDTH-1:0] re;
        logic [PART_WIDTH-1:0] im;
        logic [CNT_W-1:0] pos;
        wait_idle();
        send_idle_on = 1'b0;
        hold_request = 400;
        repeat (24) begin
            random_op(code, re, im, pos);
            send_item(code, re, im, pos);
        end
        send_idle_on = 1'b1;
    endtask

    task automatic test_random_ops(input int n_items, input int cap);
        logic [FUNC_W-1:0] code;
        logic [PART_WIDTH-1:0] re;
        logic [PART_WIDTH-1:0] im;
        logic [CNT_W-1:0] pos;
        set_capacity(cap);
        for (int n = 0; n < n_items; n++) begin
            // switch idling on and off in stretches
            if (n % 64 == 0) begin
                send_idle_on = ($urandom_range(0, 3) != 0);
                recv_idle_on = ($urandom_range(0, 3) != 0);
            end
            random_op(code, re, im, pos);
            send_item(code, re, im, pos);
        end
    endtask

    // result ready with random stalls and the requested hold-off
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (recv_idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
        end
    endtask

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin
        stack_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item, expected none, actual %h/%b",
                         $time, m_tdata, m_tuser);
            end else begin
                exp_res = pending_results.pop_front();
                check_field("real_out", int'($signed(exp_res.re)),
                            int'($signed(m_tdata[PART_WIDTH-1:0])));
                check_field("imag_out", int'($signed(exp_res.im)),
                            int'($signed(m_tdata[2*PART_WIDTH-1:PART_WIDTH])));
                check_field("fault", int'(exp_res.fault), int'(m_tuser[0]));
                check_field("fill_count", int'(exp_res.count),
                            int'(m_tdata[2*PART_WIDTH+CNT_W-1:2*PART_WIDTH]));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_store();
        test_stack_ops();
        test_capacity_limit();
        test_backpressure();
        test_random_ops(600, DEPTH);
        test_random_ops(300, 127);
        test_random_ops(200, 5);
        test_random_ops(100, 0);
        test_random_ops(100, 1);
        test_random_ops(200, DEPTH);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
